FILE: src/crps_pkg.sv
// ----------------------------------------------------------------------------
// crps_pkg: shared types and constants of the Catmull-Rom path smoother
// Holds the basis weight format, the point selection codes, the controller
// state encoding and the command and status groups between the two units.
// ----------------------------------------------------------------------------
`default_nettype none

package crps_pkg;

  // Basis weights carry 15 fraction bits and span [-1, 1].
  localparam int unsigned WFRAC    = 15;
  localparam int unsigned WEIGHT_W = WFRAC + 2;

  typedef logic signed [WEIGHT_W-1:0] weight_t;

  // Which stored points feed the four basis taps.
  typedef enum logic [2:0] {
    SEL_A2  = 3'd0,  // first segment of a path: h1, h1, h0, cur
    SEL_A3  = 3'd1,  // interior segment: h2, h1, h0, cur
    SEL_B   = 3'd2,  // closing segment: h1, h0, cur, cur
    SEL_H0  = 3'd3,  // pass-through of the stored point
    SEL_CUR = 3'd4   // pass-through of the current point
  } sel_e;

  // Controller states, one-hot.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SEG   = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // capture the incoming point
    logic issue;  // start one sample into the pipeline
    logic last;   // the issued sample is the last one for this point
    sel_e sel;    // tap selection for the issued sample
    logic shift;  // push the current point into the history
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_en;     // the pipeline advances this cycle
    logic pipe_busy;  // a sample is still inside the arithmetic stages
  } sts_t;

endpackage

`default_nettype wire

FILE: src/crps_in_if.sv
// ----------------------------------------------------------------------------
// crps_in_if: path point channel
// Valid/ready channel that carries one path point and its end-of-path flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface crps_in_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_in;
  logic signed [COORD_BITS-1:0] y_in;
  logic                         path_end;

  modport source (output valid, output x_in, output y_in, output path_end, input ready);
  modport sink   (input valid, input x_in, input y_in, input path_end, output ready);
endinterface

`default_nettype wire

FILE: src/crps_out_if.sv
// ----------------------------------------------------------------------------
// crps_out_if: smoothed sample channel
// Valid/ready channel that carries one curve sample and its run-last flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface crps_out_if #(
  parameter int unsigned COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] x_out;
  logic signed [COORD_BITS-1:0] y_out;
  logic                         run_last;

  modport source (output valid, output x_out, output y_out, output run_last, input ready);
  modport sink   (input valid, input x_out, input y_out, input run_last, output ready);
endinterface

`default_nettype wire

FILE: src/crps_ctrl.sv
// ----------------------------------------------------------------------------
// crps_ctrl: sample sequencer
// Counts the points of the current path, decides which segments a point
// produces and walks the sample index, one sample per cycle unless stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module crps_ctrl #(
  parameter int unsigned SAMPLES = 20
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  input  wire logic                               path_end_i,
  output      logic                               in_ready_o,
  input  wire crps_pkg::sts_t                     sts_i,
  output      crps_pkg::cmd_t                     cmd_o,
  output      logic [$clog2(SAMPLES+1)-1:0]       s_idx_o
);

  localparam int unsigned SW = $clog2(SAMPLES + 1);
  localparam logic [SW-1:0] S_LAST = SW'(SAMPLES);
  localparam logic [SW-1:0] S_ONE  = SW'(1);

  crps_pkg::state_e state_q, state_d;
  logic [1:0]       seen_q, seen_d;
  crps_pkg::sel_e   sel_q, sel_d, sel2_q, sel2_d;
  logic [SW-1:0]    s_q, s_d, s_end_q, s_end_d;
  logic [SW-1:0]    s2_first_q, s2_first_d, s2_end_q, s2_end_d;
  logic             two_q, two_d, end_q, end_d;

  // Next-state and command decode.
  always_comb begin
    state_d    = state_q;
    seen_d     = seen_q;
    sel_d      = sel_q;
    sel2_d     = sel2_q;
    s_d        = s_q;
    s_end_d    = s_end_q;
    s2_first_d = s2_first_q;
    s2_end_d   = s2_end_q;
    two_d      = two_q;
    end_d      = end_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.sel  = sel_q;

    unique case (state_q)
      crps_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          end_d      = path_end_i;
          seen_d     = path_end_i ? 2'd0 : ((seen_q == 2'd3) ? 2'd3 : seen_q + 2'd1);
          // Defaults: a regular segment, and the closing one at a path end.
          sel2_d     = crps_pkg::SEL_B;
          s2_first_d = S_ONE;
          s2_end_d   = S_LAST;
          two_d      = path_end_i;
          s_d        = S_ONE;
          s_end_d    = S_LAST;
          state_d    = crps_pkg::ST_SEG;
          unique case (seen_q)
            2'd0: begin
              // A lone point passes through; otherwise it is only stored.
              sel_d   = crps_pkg::SEL_CUR;
              s_d     = '0;
              s_end_d = '0;
              two_d   = 1'b0;
              if (!path_end_i) begin
                state_d = crps_pkg::ST_DRAIN;
              end
            end
            2'd1: begin
              // A two-point path returns both points unchanged.
              sel_d      = crps_pkg::SEL_H0;
              s_d        = '0;
              s_end_d    = '0;
              sel2_d     = crps_pkg::SEL_CUR;
              s2_first_d = '0;
              s2_end_d   = '0;
              if (!path_end_i) begin
                state_d = crps_pkg::ST_DRAIN;
              end
            end
            2'd2: begin
              // The first segment of a path also emits its start point.
              sel_d = crps_pkg::SEL_A2;
              s_d   = '0;
            end
            default: begin
              sel_d = crps_pkg::SEL_A3;
            end
          endcase
        end
      end

      crps_pkg::ST_SEG: begin
        if (sts_i.out_en) begin
          cmd_o.issue = 1'b1;
          cmd_o.last  = (s_q == s_end_q) && !two_q;
          if (s_q == s_end_q) begin
            if (two_q) begin
              sel_d   = sel2_q;
              s_d     = s2_first_q;
              s_end_d = s2_end_q;
              two_d   = 1'b0;
            end else begin
              state_d = crps_pkg::ST_DRAIN;
            end
          end else begin
            s_d = s_q + S_ONE;
          end
        end
      end

      crps_pkg::ST_DRAIN: begin
        // Wait until every sample has left the arithmetic stages.
        if (!sts_i.pipe_busy) begin
          cmd_o.shift = !end_q;
          state_d     = crps_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = crps_pkg::ST_IDLE;
      end
    endcase
  end

  assign s_idx_o = s_q;

  // Controller registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= crps_pkg::ST_IDLE;
      seen_q     <= '0;
      sel_q      <= crps_pkg::SEL_CUR;
      sel2_q     <= crps_pkg::SEL_CUR;
      s_q        <= '0;
      s_end_q    <= '0;
      s2_first_q <= '0;
      s2_end_q   <= '0;
      two_q      <= 1'b0;
      end_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      seen_q     <= seen_d;
      sel_q      <= sel_d;
      sel2_q     <= sel2_d;
      s_q        <= s_d;
      s_end_q    <= s_end_d;
      s2_first_q <= s2_first_d;
      s2_end_q   <= s2_end_d;
      two_q      <= two_d;
      end_q      <= end_d;
    end
  end

endmodule

`default_nettype wire

FILE: src/crps_dp.sv
// ----------------------------------------------------------------------------
// crps_dp: sample datapath
// Point history, basis weight table and a five-stage multiply-accumulate
// pipeline with rounding, saturation and an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module crps_dp #(
  parameter int unsigned SAMPLES    = 20,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic signed [COORD_BITS-1:0] x_i,
  input  wire logic signed [COORD_BITS-1:0] y_i,
  input  wire crps_pkg::cmd_t               cmd_i,
  input  wire logic [$clog2(SAMPLES+1)-1:0] s_idx_i,
  output      crps_pkg::sts_t               sts_o,
  output      logic signed [COORD_BITS-1:0] x_o,
  output      logic signed [COORD_BITS-1:0] y_o,
  output      logic                         last_o,
  output      logic                         valid_o,
  input  wire logic                         ready_i
);

  localparam int unsigned CW  = COORD_BITS;
  localparam int unsigned WW  = crps_pkg::WEIGHT_W;
  localparam int unsigned PW  = CW + WW;
  localparam int unsigned P1W = PW + 1;
  localparam int unsigned AW  = PW + 2;

  localparam logic signed [AW-1:0] HALF    = AW'(longint'(1) << (crps_pkg::WFRAC - 1));
  localparam logic signed [AW-1:0] HALF_M1 = AW'((longint'(1) << (crps_pkg::WFRAC - 1)) - 1);
  localparam logic signed [AW-1:0] SAT_HI  = AW'((longint'(1) << (CW - 1)) - 1);
  localparam logic signed [AW-1:0] SAT_LO  = AW'(-(longint'(1) << (CW - 1)));

  localparam longint SL  = longint'(SAMPLES);
  localparam longint SL2 = SL * SL;
  localparam longint SL3 = SL2 * SL;
  localparam longint DEN = 2 * SL3;
  localparam longint ONE = longint'(1) << crps_pkg::WFRAC;

  // Basis weight table, one row per sample index, rounded half away from zero.
  crps_pkg::weight_t w_tbl [SAMPLES+1][4];

  for (genvar gs = 0; gs <= SAMPLES; gs++) begin : g_wtab
    localparam longint LS = longint'(gs);
    localparam longint N0 = (-LS * SL2 + 2 * LS * LS * SL - LS * LS * LS) * ONE;
    localparam longint N1 = (2 * SL3 - 5 * LS * LS * SL + 3 * LS * LS * LS) * ONE;
    localparam longint N2 = (LS * SL2 + 4 * LS * LS * SL - 3 * LS * LS * LS) * ONE;
    localparam longint N3 = (-LS * LS * SL + LS * LS * LS) * ONE;
    localparam longint W0 = (N0 >= 0) ? (N0 + DEN / 2) / DEN : -((-N0 + DEN / 2) / DEN);
    localparam longint W1 = (N1 >= 0) ? (N1 + DEN / 2) / DEN : -((-N1 + DEN / 2) / DEN);
    localparam longint W2 = (N2 >= 0) ? (N2 + DEN / 2) / DEN : -((-N2 + DEN / 2) / DEN);
    localparam longint W3 = (N3 >= 0) ? (N3 + DEN / 2) / DEN : -((-N3 + DEN / 2) / DEN);
    assign w_tbl[gs][0] = WW'(W0);
    assign w_tbl[gs][1] = WW'(W1);
    assign w_tbl[gs][2] = WW'(W2);
    assign w_tbl[gs][3] = WW'(W3);
  end

  // Point storage: current point and three history points, newest first.
  logic signed [CW-1:0] cur_x_q, cur_y_q;
  logic signed [CW-1:0] hx_q [3];
  logic signed [CW-1:0] hy_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cur_x_q <= x_i;
      cur_y_q <= y_i;
    end
    if (cmd_i.shift) begin
      hx_q[2] <= hx_q[1];
      hy_q[2] <= hy_q[1];
      hx_q[1] <= hx_q[0];
      hy_q[1] <= hy_q[0];
      hx_q[0] <= cur_x_q;
      hy_q[0] <= cur_y_q;
    end
  end

  // Tap selection for the sample being issued.
  logic signed [CW-1:0] px [4];
  logic signed [CW-1:0] py [4];

  always_comb begin
    unique case (cmd_i.sel)
      crps_pkg::SEL_A2: begin
        px = '{hx_q[1], hx_q[1], hx_q[0], cur_x_q};
        py = '{hy_q[1], hy_q[1], hy_q[0], cur_y_q};
      end
      crps_pkg::SEL_A3: begin
        px = '{hx_q[2], hx_q[1], hx_q[0], cur_x_q};
        py = '{hy_q[2], hy_q[1], hy_q[0], cur_y_q};
      end
      crps_pkg::SEL_B: begin
        px = '{hx_q[1], hx_q[0], cur_x_q, cur_x_q};
        py = '{hy_q[1], hy_q[0], cur_y_q, cur_y_q};
      end
      crps_pkg::SEL_H0: begin
        px = '{hx_q[0], hx_q[0], hx_q[0], hx_q[0]};
        py = '{hy_q[0], hy_q[0], hy_q[0], hy_q[0]};
      end
      default: begin
        px = '{cur_x_q, cur_x_q, cur_x_q, cur_x_q};
        py = '{cur_y_q, cur_y_q, cur_y_q, cur_y_q};
      end
    endcase
  end

  // Round half away from zero, drop the weight fraction, saturate.
  function automatic logic signed [CW-1:0] round_sat(input logic signed [AW-1:0] acc);
    logic signed [AW-1:0] rnd;
    logic signed [AW-1:0] quo;
    logic signed [CW-1:0] res;
    rnd = acc + (acc[AW-1] ? HALF_M1 : HALF);
    quo = rnd >>> crps_pkg::WFRAC;
    if (quo > SAT_HI) begin
      res = CW'(SAT_HI);
    end else if (quo < SAT_LO) begin
      res = CW'(SAT_LO);
    end else begin
      res = CW'(quo);
    end
    return res;
  endfunction

  // Pipeline registers.
  logic                 en;
  logic                 s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic                 s1_l_q, s2_l_q, s3_l_q, s4_l_q, out_l_q;
  crps_pkg::weight_t    s1_w_q  [4];
  logic signed [CW-1:0] s1_px_q [4];
  logic signed [CW-1:0] s1_py_q [4];
  logic signed [PW-1:0] s2_mx_q [4];
  logic signed [PW-1:0] s2_my_q [4];
  logic signed [P1W-1:0] s3_ax_q [2];
  logic signed [P1W-1:0] s3_ay_q [2];
  logic signed [AW-1:0] s4_ax_q, s4_ay_q;
  logic signed [CW-1:0] out_x_q, out_y_q;

  // The whole pipeline holds while a finished sample waits at the output.
  assign en = !out_v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= cmd_i.issue;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      s4_v_q  <= s3_v_q;
      out_v_q <= s4_v_q;
    end
  end

  // Stage payloads: fetch, multiply, pair sums, final sum, round and saturate.
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        s1_w_q[i]  <= w_tbl[s_idx_i][i];
        s1_px_q[i] <= px[i];
        s1_py_q[i] <= py[i];
        s2_mx_q[i] <= s1_w_q[i] * s1_px_q[i];
        s2_my_q[i] <= s1_w_q[i] * s1_py_q[i];
      end
      for (int j = 0; j < 2; j++) begin
        s3_ax_q[j] <= P1W'(s2_mx_q[2*j]) + P1W'(s2_mx_q[2*j+1]);
        s3_ay_q[j] <= P1W'(s2_my_q[2*j]) + P1W'(s2_my_q[2*j+1]);
      end
      s4_ax_q <= AW'(s3_ax_q[0]) + AW'(s3_ax_q[1]);
      s4_ay_q <= AW'(s3_ay_q[0]) + AW'(s3_ay_q[1]);
      out_x_q <= round_sat(s4_ax_q);
      out_y_q <= round_sat(s4_ay_q);
      s1_l_q  <= cmd_i.last;
      s2_l_q  <= s1_l_q;
      s3_l_q  <= s2_l_q;
      s4_l_q  <= s3_l_q;
      out_l_q <= s4_l_q;
    end
  end

  assign sts_o.out_en    = en;
  assign sts_o.pipe_busy = s1_v_q || s2_v_q || s3_v_q || s4_v_q;

  assign x_o     = out_x_q;
  assign y_o     = out_y_q;
  assign last_o  = out_l_q;
  assign valid_o = out_v_q;

endmodule

`default_nettype wire

FILE: src/catmull_rom_path_smoother.sv
// ----------------------------------------------------------------------------
// catmull_rom_path_smoother: streaming uniform Catmull-Rom path smoother
// Turns a stream of 2D path points into fixed-point spline samples.
// ----------------------------------------------------------------------------
// Usage:
//   Points arrive on pt_i (x_in, y_in, path_end) and samples leave on smp_o
//   (x_out, y_out, run_last); both are valid/ready channels and a transfer
//   happens when valid and ready are both high. run_last marks the final
//   sample caused by one input point.
//   One point is taken at a time. The sequencer issues one sample per cycle
//   into a five-stage multiply-accumulate pipeline while smp_o does not
//   stall. A point yields SAMPLES samples as an interior point and
//   2*SAMPLES when it ends a path of three or more points, one more when
//   the point opens the first segment of a path. The end point of a
//   one- or two-point path passes that path's points through unchanged;
//   other points of such a path are only stored and yield no sample.
//   A stall on smp_o freezes the whole pipeline; the last finished sample
//   stays in the output register while the next point is already taken.
//   Reset clears the point count, so the next point starts a new path, and
//   empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module catmull_rom_path_smoother #(
  parameter int unsigned SAMPLES    = 20,
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  crps_in_if.sink    pt_i,
  crps_out_if.source smp_o
);

  localparam int unsigned SW = $clog2(SAMPLES + 1);

  crps_pkg::cmd_t cmd;
  crps_pkg::sts_t sts;
  logic [SW-1:0]  s_idx;

  // Sequencer.
  crps_ctrl #(
    .SAMPLES (SAMPLES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pt_i.valid),
    .path_end_i (pt_i.path_end),
    .in_ready_o (pt_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .s_idx_o    (s_idx)
  );

  // Arithmetic and point storage.
  crps_dp #(
    .SAMPLES    (SAMPLES),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .x_i     (pt_i.x_in),
    .y_i     (pt_i.y_in),
    .cmd_i   (cmd),
    .s_idx_i (s_idx),
    .sts_o   (sts),
    .x_o     (smp_o.x_out),
    .y_o     (smp_o.y_out),
    .last_o  (smp_o.run_last),
    .valid_o (smp_o.valid),
    .ready_i (smp_o.ready)
  );

  // A new point is only taken once the arithmetic stages are empty.
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pt_i.ready |-> !sts.pipe_busy)
    else $error("point accepted while samples are in flight");

  // Samples enter the pipeline only when it advances.
  a_issue_en: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.issue |-> sts.out_en)
    else $error("sample issued into a held pipeline");

  // The history shifts only after the last sample has left the stages.
  a_shift_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.shift |-> !sts.pipe_busy && !cmd.issue)
    else $error("history shifted while samples are in flight");

endmodule

`default_nettype wire

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the Catmull-Rom path smoother
// Feeds paths of 2D points through the point channel and checks every sample
// against a predictor of the uniform Catmull-Rom subdivision, with random
// idling on both channels and long output stalls that back up the input.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int unsigned SAMPLES    = 20;
  localparam int unsigned COORD_BITS = 16;

  localparam longint WEIGHT_ONE = longint'(1) << crps_pkg::WFRAC;
  localparam longint COORD_MAX  = (longint'(1) << (COORD_BITS - 1)) - 1;
  localparam longint COORD_MIN  = -COORD_MAX - 1;

  localparam int CYCLE_LIMIT   = 250000;
  localparam int DRAIN_CYCLES  = 32;
  localparam int RANDOM_POINTS = 114;
  localparam int HOLD_CYCLES   = 300;

  // Shapes of random paths.
  localparam int STYLE_WALK    = 0;
  localparam int STYLE_WILD    = 1;
  localparam int STYLE_EXTREME = 2;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   path_end;
  } point_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   run_last;
  } sample_t;

  logic clk_i;
  logic rst_ni;

  crps_in_if  #(.COORD_BITS(COORD_BITS)) pt_if  ();
  crps_out_if #(.COORD_BITS(COORD_BITS)) smp_if ();

  catmull_rom_path_smoother #(
    .SAMPLES   (SAMPLES),
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .pt_i  (pt_if),
    .smp_o (smp_if)
  );

  point_t  pending_points[$];
  sample_t expected_samples[$];

  // Predictor state: newest stored point first, and points seen, up to three.
  coord_t      hist_x[3];
  coord_t      hist_y[3];
  int unsigned path_len;
  coord_t      tap_x[4];
  coord_t      tap_y[4];

  point_t offered_point;
  int     total_points;
  int     points_offered;
  int     points_accepted;
  int     send_gap;
  int     samples_seen;
  int     stall_left;
  int     hold_left;
  int     mismatches;
  int     cycle_count;

  // ---------------------------------------------------------------------------
  // Spline arithmetic
  // ---------------------------------------------------------------------------

  // Division rounded to nearest, ties away from zero.
  function automatic longint round_half_away(input longint num, input longint den);
    if (num >= 0) begin
      return (num + den / 2) / den;
    end
    return -((-num + den / 2) / den);
  endfunction

  function automatic coord_t clip_coord(input longint v);
    if (v > COORD_MAX) begin
      return coord_t'(COORD_MAX);
    end
    if (v < COORD_MIN) begin
      return coord_t'(COORD_MIN);
    end
    return coord_t'(v);
  endfunction

  // Basis weight of one tap at t = s/SAMPLES, with WFRAC fraction bits.
  function automatic longint basis_weight(input int tap, input longint s);
    longint n;
    longint num;
    n = SAMPLES;
    case (tap)
      0: begin
        num = -s * n * n + 2 * s * s * n - s * s * s;
      end
      1: begin
        num = 2 * n * n * n - 5 * s * s * n + 3 * s * s * s;
      end
      2: begin
        num = s * n * n + 4 * s * s * n - 3 * s * s * s;
      end
      default: begin
        num = -s * s * n + s * s * s;
      end
    endcase
    return round_half_away(num * WEIGHT_ONE, 2 * n * n * n);
  endfunction

  task automatic push_sample(input coord_t x, input coord_t y);
    sample_t smp;
    smp.x        = x;
    smp.y        = y;
    smp.run_last = 1'b0;
    expected_samples = {expected_samples, smp};
  endtask

  // Samples s = first..SAMPLES of the segment between taps 1 and 2.
  task automatic emit_segment(input int first);
    longint acc_x;
    longint acc_y;
    longint w;
    for (int s = first; s <= SAMPLES; s++) begin
      acc_x = 0;
      acc_y = 0;
      for (int i = 0; i < 4; i++) begin
        w     = basis_weight(i, s);
        acc_x += w * longint'(tap_x[i]);
        acc_y += w * longint'(tap_y[i]);
      end
      push_sample(clip_coord(round_half_away(acc_x, WEIGHT_ONE)),
                  clip_coord(round_half_away(acc_y, WEIGHT_ONE)));
    end
  endtask

  // Expected samples caused by one accepted point; updates the path history.
  task automatic predict_point(input point_t pt);
    int base;
    base = expected_samples.size();
    case (path_len)
      0: begin
        if (pt.path_end) begin
          push_sample(pt.x, pt.y);
        end
      end
      1: begin
        if (pt.path_end) begin
          push_sample(hist_x[0], hist_y[0]);
          push_sample(pt.x, pt.y);
        end
      end
      2: begin
        // First segment: the start point stands in for its missing neighbor.
        tap_x = '{hist_x[1], hist_x[1], hist_x[0], pt.x};
        tap_y = '{hist_y[1], hist_y[1], hist_y[0], pt.y};
        emit_segment(0);
      end
      default: begin
        tap_x = '{hist_x[2], hist_x[1], hist_x[0], pt.x};
        tap_y = '{hist_y[2], hist_y[1], hist_y[0], pt.y};
        emit_segment(1);
      end
    endcase

    // The final point closes the last segment with itself as the far tap.
    if (pt.path_end && path_len >= 2) begin
      tap_x = '{hist_x[1], hist_x[0], pt.x, pt.x};
      tap_y = '{hist_y[1], hist_y[0], pt.y, pt.y};
      emit_segment(1);
    end

    if (pt.path_end) begin
      path_len = 0;
    end else begin
      hist_x[2] = hist_x[1];
      hist_y[2] = hist_y[1];
      hist_x[1] = hist_x[0];
      hist_y[1] = hist_y[0];
      hist_x[0] = pt.x;
      hist_y[0] = pt.y;
      if (path_len < 3) begin
        path_len++;
      end
    end

    if (expected_samples.size() > base) begin
      expected_samples[expected_samples.size() - 1].run_last = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic add_point(input longint x, input longint y, input bit last_pt);
    point_t pt;
    pt.x        = clip_coord(x);
    pt.y        = clip_coord(y);
    pt.path_end = last_pt;
    pending_points = {pending_points, pt};
  endtask

  function automatic int rand_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int rand_extreme();
    case ($urandom_range(0, 3))
      0: begin
        return int'(COORD_MIN);
      end
      1: begin
        return int'(COORD_MAX);
      end
      2: begin
        return int'(COORD_MIN) + int'($urandom_range(0, 255));
      end
      default: begin
        return int'(COORD_MAX) - int'($urandom_range(0, 255));
      end
    endcase
  endfunction

  // One whole path of len points; the last one carries path_end.
  task automatic queue_path(input int len, input int style);
    int px;
    int py;
    px = rand_coord();
    py = rand_coord();
    for (int k = 0; k < len; k++) begin
      case (style)
        STYLE_WALK: begin
          px = int'(clip_coord(px + int'($urandom_range(0, 4000)) - 2000));
          py = int'(clip_coord(py + int'($urandom_range(0, 4000)) - 2000));
        end
        STYLE_WILD: begin
          px = rand_coord();
          py = rand_coord();
        end
        default: begin
          px = rand_extreme();
          py = rand_extreme();
        end
      endcase
      add_point(px, py, k == len - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock, and known values on every input from time zero
  // ---------------------------------------------------------------------------
  initial begin
    clk_i           = 1'b0;
    rst_ni          = 1'b0;
    pt_if.valid     = 1'b0;
    pt_if.x_in      = '0;
    pt_if.y_in      = '0;
    pt_if.path_end  = 1'b0;
    smp_if.ready    = 1'b0;
    forever begin
      #4 clk_i = ~clk_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Point driver: offers queued points and predicts each accepted transfer
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pt_if.valid    <= 1'b0;
      pt_if.x_in     <= '0;
      pt_if.y_in     <= '0;
      pt_if.path_end <= 1'b0;
      send_gap       = 0;
      path_len       = 0;
    end else begin
      if (pt_if.valid && pt_if.ready) begin
        predict_point(offered_point);
        points_accepted++;
      end
      if (!pt_if.valid || pt_if.ready) begin
        if (send_gap > 0 || pending_points.size() == 0) begin
          if (send_gap > 0) begin
            send_gap--;
          end
          pt_if.valid <= 1'b0;
        end else begin
          offered_point = pending_points.pop_front();
          pt_if.valid    <= 1'b1;
          pt_if.x_in     <= offered_point.x;
          pt_if.y_in     <= offered_point.y;
          pt_if.path_end <= offered_point.path_end;
          points_offered++;
          // A stretch of back-to-back points in the middle of the run.
          if (points_offered >= 40 && points_offered < 70) begin
            send_gap = 0;
          end else begin
            send_gap = $urandom_range(0, 3);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sample monitor: checks each transfer and paces ready
  // ---------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    logic    next_ready;
    sample_t got;
    sample_t want;
    if (!rst_ni) begin
      smp_if.ready <= 1'b0;
      stall_left   = 0;
      hold_left    = 0;
    end else begin
      if (smp_if.valid && smp_if.ready) begin
        got.x        = smp_if.x_out;
        got.y        = smp_if.y_out;
        got.run_last = smp_if.run_last;
        if (expected_samples.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected sample x=%0d y=%0d run_last=%0b",
                   $time, got.x, got.y, got.run_last);
        end else begin
          want = expected_samples.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: sample %0d expected x=%0d y=%0d run_last=%0b, %s",
                     $time, samples_seen, want.x, want.y, want.run_last,
                     $sformatf("got x=%0d y=%0d run_last=%0b",
                               got.x, got.y, got.run_last));
          end
        end
        samples_seen++;
        if (samples_seen >= 600 && samples_seen < 900) begin
          stall_left = 0;
        end else begin
          stall_left = $urandom_range(0, 3);
        end
        // Long back-pressure so the block fills up and refuses points.
        if (samples_seen == 150 || samples_seen == 1000) begin
          hold_left = HOLD_CYCLES;
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      smp_if.ready <= next_ready;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int random_points;
    int len;
    int pick;
    int style;

    points_offered  = 0;
    points_accepted = 0;
    samples_seen    = 0;
    mismatches      = 0;
    cycle_count     = 0;
    random_points   = 0;

    // Single-point paths at opposite corners.
    add_point(COORD_MIN, COORD_MAX, 1'b1);
    add_point(COORD_MAX, COORD_MIN, 1'b1);
    // Two-point path: nothing on the first, both points on the second.
    add_point(0, 0, 1'b0);
    add_point(100, -100, 1'b1);
    // Three-point path that ends on the third point, with overshoot clipping.
    add_point(COORD_MIN, COORD_MIN, 1'b0);
    add_point(COORD_MAX, COORD_MAX, 1'b0);
    add_point(COORD_MIN, COORD_MIN, 1'b1);
    // Zig-zag between the extremes, long enough for interior segments.
    add_point(COORD_MAX, COORD_MIN, 1'b0);
    add_point(COORD_MIN, COORD_MAX, 1'b0);
    add_point(COORD_MAX, COORD_MIN, 1'b0);
    add_point(COORD_MIN, COORD_MAX, 1'b0);
    add_point(COORD_MAX, COORD_MIN, 1'b1);
    // Gentle four-point path with odd values to exercise rounding.
    add_point(-1, 1, 1'b0);
    add_point(3, -7, 1'b0);
    add_point(-11, 13, 1'b0);
    add_point(17, -19, 1'b1);

    // Random paths: mostly well-formed longer paths of mixed shapes.
    while (random_points < RANDOM_POINTS) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        len = 1;
      end else if (pick == 1) begin
        len = 2;
      end else begin
        len = $urandom_range(3, 10);
      end
      pick = $urandom_range(0, 5);
      if (pick < 3) begin
        style = STYLE_WALK;
      end else if (pick < 5) begin
        style = STYLE_WILD;
      end else begin
        style = STYLE_EXTREME;
      end
      queue_path(len, style);
      random_points += len;
    end
    total_points = pending_points.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (points_accepted < total_points) begin
      @(posedge clk_i);
    end
    while (expected_samples.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: files.f
src/crps_pkg.sv
src/crps_in_if.sv
src/crps_out_if.sv
src/crps_ctrl.sv
src/crps_dp.sv
src/catmull_rom_path_smoother.sv
dv/tb_top.sv
